@@ src/nrps_pkg.sv @@
`timescale 1ns / 1ps

package nrps_pkg;

  localparam int unsigned FIELD_BITS = 32;
  localparam int unsigned PCT_BITS   = 7;
  localparam int unsigned APB_AW     = 3;
  localparam int unsigned APB_DW     = 32;

  localparam logic [0:0]          REG_PERCENT   = 1'b0;
  localparam logic [PCT_BITS-1:0] PERCENT_RESET = 7'd50;
  localparam logic [PCT_BITS-1:0] PERCENT_FULL  = 7'd100;

  localparam int unsigned RECIP_SHIFT = 24;
  localparam int unsigned RECIP_BITS  = 18;
  localparam logic [RECIP_BITS-1:0] RECIP = 18'd167773;

  typedef struct packed {
    logic ins;
    logic shift;
  } cell_ctrl_t;

endpackage

@@ src/nrps_if.sv @@
`timescale 1ns / 1ps

interface nrps_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] sample;
  logic        has_sample;
  logic        last;

  modport source (output valid, output sample, output has_sample, output last, input ready);
  modport sink (input valid, input sample, input has_sample, input last, output ready);
endinterface

interface nrps_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] percentile_value;
  logic        set_empty;
  logic        samples_dropped;

  modport source (output valid, output percentile_value, output set_empty,
                  output samples_dropped, input ready);
  modport sink (input valid, input percentile_value, input set_empty,
                input samples_dropped, output ready);
endinterface

@@ src/nrps_cell.sv @@
`timescale 1ns / 1ps

module nrps_cell #(
  parameter int unsigned SB    = 32,
  parameter int unsigned CNT_W = 7,
  parameter int unsigned IDX   = 0
) (
  input  logic                clk_i,
  input  nrps_pkg::cell_ctrl_t ctrl_i,
  input  logic [SB-1:0]       x_i,
  input  logic [CNT_W-1:0]    count_i,
  input  logic [SB-1:0]       prev_v_i,
  input  logic                prev_gt_i,
  input  logic [SB-1:0]       next_v_i,
  output logic [SB-1:0]       v_o,
  output logic                gt_o
);
  import nrps_pkg::*;

  logic [SB-1:0] v_q;
  logic [SB-1:0] v_d;
  logic          occupied;

  assign occupied = CNT_W'(IDX) < count_i;
  assign gt_o     = !occupied || (v_q > x_i);
  assign v_o      = v_q;

  always_comb begin
    v_d = v_q;
    if (ctrl_i.shift) begin
      v_d = next_v_i;
    end else if (ctrl_i.ins && gt_o) begin
      v_d = prev_gt_i ? prev_v_i : x_i;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q <= v_d;
  end

endmodule

@@ src/nrps_chain.sv @@
`timescale 1ns / 1ps

module nrps_chain #(
  parameter int unsigned SB    = 32,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned CNT_W = 7
) (
  input  logic                 clk_i,
  input  nrps_pkg::cell_ctrl_t ctrl_i,
  input  logic [SB-1:0]        x_i,
  input  logic [CNT_W-1:0]     count_i,
  output logic [SB-1:0]        head_o
);
  import nrps_pkg::*;

  logic [SB-1:0] v    [DEPTH];
  logic          gt   [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [SB-1:0] prev_v;
    logic          prev_gt;
    logic [SB-1:0] next_v;

    if (i == 0) begin : g_first
      assign prev_v  = x_i;
      assign prev_gt = 1'b0;
    end else begin : g_mid
      assign prev_v  = v[i-1];
      assign prev_gt = gt[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_v = v[i];
    end else begin : g_inner
      assign next_v = v[i+1];
    end

    nrps_cell #(
      .SB   (SB),
      .CNT_W(CNT_W),
      .IDX  (i)
    ) u_cell (
      .clk_i    (clk_i),
      .ctrl_i   (ctrl_i),
      .x_i      (x_i),
      .count_i  (count_i),
      .prev_v_i (prev_v),
      .prev_gt_i(prev_gt),
      .next_v_i (next_v),
      .v_o      (v[i]),
      .gt_o     (gt[i])
    );
  end

  assign head_o = v[0];

endmodule

@@ src/nrps_rank.sv @@
`timescale 1ns / 1ps

module nrps_rank #(
  parameter int unsigned CNT_W = 7
) (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic [nrps_pkg::PCT_BITS-1:0]      percent_i,
  input  logic [CNT_W-1:0]                   count_i,
  output logic [CNT_W-1:0]                   sel_o
);
  import nrps_pkg::*;

  localparam int unsigned PW = PCT_BITS + CNT_W;
  localparam int unsigned MW = PW + RECIP_BITS;
  localparam int unsigned RW = CNT_W + 1;

  logic [PCT_BITS-1:0] pct;
  logic [PW-1:0]       prod_q;
  logic [PW-1:0]       prod_d;
  logic [CNT_W-1:0]    n_q;
  logic [MW-1:0]       scaled;
  logic [RW-1:0]       rank;
  logic [RW-1:0]       rank_c;

  assign pct    = (percent_i > PERCENT_FULL) ? PERCENT_FULL : percent_i;
  assign prod_d = PW'(pct) * PW'(count_i) + PW'(PERCENT_FULL - 7'd1);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      n_q    <= count_i;
    end
  end

  assign scaled = MW'(prod_q) * MW'(RECIP);
  assign rank   = scaled[RECIP_SHIFT +: RW];

  always_comb begin
    rank_c = rank;
    if (rank_c == '0) begin
      rank_c = RW'(1);
    end
    if (rank_c > RW'(n_q)) begin
      rank_c = RW'(n_q);
    end
  end

  assign sel_o = CNT_W'(rank_c - RW'(1));

endmodule

@@ src/nearest_rank_percentile_select.sv @@
`timescale 1ns / 1ps

// Channel   Dir  Transfer when         Payload
// in_i      in   valid && ready        sample, has_sample, last
// out_o     out  valid && ready        percentile_value, set_empty, samples_dropped
// apb       in   psel&&penable&&pwrite percent (register 0, paddr[2] clear)
//
// Samples stream back to back while a set loads. After an item with last, input
// stalls through S_MUL, S_DIV and S_SEL; in S_SEL the chain shifts rank - 1 places
// toward cell 0, one place per cycle (rank up to MAX_SAMPLES), then the result is
// registered once the output is free. A pending result does not block loading.
// Reset clears count, drop flag and output valid, and sets percent to 50.
module nearest_rank_percentile_select #(
  parameter int unsigned MAX_SAMPLES = 64,
  parameter int unsigned SAMPLE_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  nrps_in_if.sink                       in_i,
  nrps_out_if.source                    out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [nrps_pkg::APB_AW-1:0]   paddr,
  input  logic [nrps_pkg::APB_DW-1:0]   pwdata,
  output logic [nrps_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);
  import nrps_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_SAMPLES);

  typedef enum logic [3:0] {
    S_LOAD = 4'b0001,
    S_MUL  = 4'b0010,
    S_DIV  = 4'b0100,
    S_SEL  = 4'b1000
  } state_e;

  state_e              state_q, state_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic                ovf_q, ovf_d;
  logic [CNT_W-1:0]    sh_q, sh_d;
  logic [PCT_BITS-1:0] percent_q;
  logic                out_valid_q, out_valid_d;
  logic [31:0]         out_value_q;
  logic                out_empty_q;
  logic                out_drop_q;
  logic                out_load;
  logic                in_xfer;
  logic                empty;
  logic                cfg_wr;
  cell_ctrl_t          ctrl;
  logic [SAMPLE_BITS-1:0] head;
  logic [CNT_W-1:0]    sel;

  assign pready = 1'b1;
  assign prdata = APB_DW'(percent_q);
  assign cfg_wr = psel && penable && pwrite && (paddr[APB_AW-1] == REG_PERCENT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      percent_q <= PERCENT_RESET;
    end else if (cfg_wr) begin
      percent_q <= pwdata[PCT_BITS-1:0];
    end
  end

  assign in_i.ready = (state_q == S_LOAD);
  assign in_xfer    = in_i.valid && in_i.ready;
  assign empty      = (count_q == '0);

  assign ctrl.ins   = in_xfer && in_i.has_sample && (count_q != CNT_FULL);
  assign ctrl.shift = (state_q == S_SEL) && (sh_q != '0);

  nrps_chain #(
    .SB   (SAMPLE_BITS),
    .DEPTH(MAX_SAMPLES),
    .CNT_W(CNT_W)
  ) u_chain (
    .clk_i  (clk_i),
    .ctrl_i (ctrl),
    .x_i    (SAMPLE_BITS'(in_i.sample)),
    .count_i(count_q),
    .head_o (head)
  );

  nrps_rank #(
    .CNT_W(CNT_W)
  ) u_rank (
    .clk_i    (clk_i),
    .en_i     (state_q == S_MUL),
    .percent_i(percent_q),
    .count_i  (count_q),
    .sel_o    (sel)
  );

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    ovf_d       = ovf_q;
    sh_d        = sh_q;
    out_load    = 1'b0;
    out_valid_d = out_valid_q && !out_o.ready;
    unique case (state_q)
      S_LOAD: begin
        if (in_xfer) begin
          if (in_i.has_sample) begin
            if (count_q == CNT_FULL) begin
              ovf_d = 1'b1;
            end else begin
              count_d = count_q + CNT_W'(1);
            end
          end
          if (in_i.last) begin
            state_d = S_MUL;
          end
        end
      end
      S_MUL: begin
        state_d = S_DIV;
      end
      S_DIV: begin
        sh_d    = empty ? '0 : sel;
        state_d = S_SEL;
      end
      S_SEL: begin
        if (sh_q != '0) begin
          sh_d = sh_q - CNT_W'(1);
        end else if (!out_valid_q || out_o.ready) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          count_d     = '0;
          ovf_d       = 1'b0;
          state_d     = S_LOAD;
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      sh_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      sh_q        <= sh_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_value_q <= empty ? 32'd0 : 32'(head);
      out_empty_q <= empty;
      out_drop_q  <= ovf_q;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.percentile_value = out_value_q;
  assign out_o.set_empty        = out_empty_q;
  assign out_o.samples_dropped  = out_drop_q;

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import nrps_pkg::*;

  localparam int unsigned STORE_DEPTH = 64;
  localparam int unsigned SETTLE_CYCLES = 80;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned HOLD_AFTER = 25;
  localparam logic [APB_AW-1:0] ADDR_PERCENT = APB_AW'(4 * int'(REG_PERCENT));
  localparam logic [APB_AW-1:0] ADDR_SPARE = APB_AW'(4);

  typedef struct packed {
    logic [31:0] value;
    logic        empty;
    logic        dropped;
  } pct_result_t;

  class percentile_tracker;
    logic [31:0]         loaded[$];
    bit                  overflow;
    logic [PCT_BITS-1:0] percent;
    pct_result_t         pending[$];
    int                  errors;

    function new();
      percent = PERCENT_RESET;
      overflow = 0;
      errors = 0;
    endfunction

    task report(string msg);
      $display("%0t mismatch: %s", $time, msg);
      errors++;
    endtask

    function void write_reg(logic [APB_AW-1:0] addr, logic [31:0] data);
      if (addr == ADDR_PERCENT) begin
        percent = data[PCT_BITS-1:0];
      end
    endfunction

    function void note_item(logic [31:0] s, logic has, logic lst);
      int pos;
      int n;
      int p;
      int rank;
      pct_result_t r;
      if (has) begin
        if (loaded.size() >= STORE_DEPTH) begin
          overflow = 1;
        end else begin
          pos = loaded.size();
          while (pos > 0 && loaded[pos-1] > s) pos--;
          if (pos == loaded.size()) loaded = {loaded, s};
          else loaded.insert(pos, s);
        end
      end
      if (!lst) return;
      n = loaded.size();
      if (n == 0) begin
        r.value = '0;
        r.empty = 1'b1;
      end else begin
        p = (percent > PERCENT_FULL) ? int'(PERCENT_FULL) : int'(percent);
        rank = (p * n + int'(PERCENT_FULL) - 1) / int'(PERCENT_FULL);
        if (rank < 1) rank = 1;
        if (rank > n) rank = n;
        r.value = loaded[rank-1];
        r.empty = 1'b0;
      end
      r.dropped = overflow;
      pending = {pending, r};
      loaded.delete();
      overflow = 0;
    endfunction

    task check_result(pct_result_t got);
      pct_result_t want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result value=%h empty=%b dropped=%b",
                         got.value, got.empty, got.dropped));
        return;
      end
      want = pending.pop_front();
      if (got.value !== want.value)
        report($sformatf("percentile_value got %h want %h", got.value, want.value));
      if (got.empty !== want.empty)
        report($sformatf("set_empty got %b want %b", got.empty, want.empty));
      if (got.dropped !== want.dropped)
        report($sformatf("samples_dropped got %b want %b", got.dropped, want.dropped));
    endtask
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  nrps_in_if  in_ch ();
  nrps_out_if out_ch ();

  percentile_tracker tracker;
  bit steady;
  int hold_left;
  int items_sent;
  int results_seen;

  nearest_rank_percentile_select dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic apb_write(logic [APB_AW-1:0] addr, logic [31:0] data);
    @(negedge clk_i);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = addr;
    pwdata = data;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    tracker.write_reg(addr, data);
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  task automatic send_item(logic [31:0] s, logic has, logic lst);
    while (!steady && $urandom_range(99) < 15) begin
      @(negedge clk_i);
      in_ch.valid = 1'b0;
    end
    @(negedge clk_i);
    in_ch.valid = 1'b1;
    in_ch.sample = s;
    in_ch.has_sample = has;
    in_ch.last = lst;
    do @(posedge clk_i); while (!in_ch.ready);
    tracker.note_item(s, has, lst);
  endtask

  task automatic end_stream();
    @(negedge clk_i);
    in_ch.valid = 1'b0;
  endtask

  task automatic drain();
    while (tracker.pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_sample(int mode);
    case (mode)
      1: return 32'($urandom_range(7));
      2: return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
      3: return 32'hFFFF_FFF0 | 32'($urandom_range(15));
      default: return $urandom;
    endcase
  endfunction

  task automatic send_set(int n);
    int mode;
    bit split;
    mode = ($urandom_range(99) < 55) ? 0 : $urandom_range(3);
    split = (n == 0) || ($urandom_range(9) < 3);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(19) == 0) send_item($urandom, 1'b0, 1'b0);
      send_item(pick_sample(mode), 1'b1, !split && (i == n - 1));
    end
    if (split) send_item($urandom, 1'b0, 1'b1);
    items_sent += n + int'(split);
  endtask

  task automatic run_phase(int budget);
    int start;
    int n;
    start = items_sent;
    while (items_sent - start < budget) begin
      n = ($urandom_range(99) < 10) ? $urandom_range(72, 60) : $urandom_range(12);
      send_set(n);
    end
    end_stream();
    drain();
  endtask

  initial begin
    pct_result_t got;
    out_ch.ready = 1'b0;
    hold_left = 0;
    results_seen = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_ch.ready = 1'b0;
        hold_left--;
      end else begin
        out_ch.ready = steady || ($urandom_range(99) >= 15);
      end
      @(posedge clk_i);
      if (out_ch.valid && out_ch.ready) begin
        got.value = out_ch.percentile_value;
        got.empty = out_ch.set_empty;
        got.dropped = out_ch.samples_dropped;
        tracker.check_result(got);
        results_seen++;
        if (results_seen == HOLD_AFTER) hold_left = HOLD_CYCLES;
      end
    end
  end

  initial begin
    logic [PCT_BITS-1:0] settings[10];
    tracker = new();
    steady = 1'b0;
    items_sent = 0;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.sample = '0;
    in_ch.has_sample = 1'b0;
    in_ch.last = 1'b0;
    settings = '{7'd0, 7'd100, 7'd127, 7'd1, 7'd99, 7'd101, 7'd0, 7'd0, PERCENT_RESET, 7'd0};
    settings[6] = 7'($urandom_range(100));
    settings[7] = 7'($urandom_range(127));
    settings[9] = 7'($urandom_range(100));
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_item(32'h0, 1'b0, 1'b1);
    send_item(32'hFFFF_FFFF, 1'b1, 1'b1);
    send_item(32'h1234_5678, 1'b0, 1'b0);
    send_item(32'h0, 1'b1, 1'b0);
    send_item(32'hFFFF_FFFF, 1'b1, 1'b0);
    send_item(32'h7, 1'b1, 1'b0);
    send_item(32'h7, 1'b1, 1'b0);
    send_item(32'hAAAA_5555, 1'b0, 1'b1);
    send_item(32'h5, 1'b1, 1'b0);
    send_item(32'h5, 1'b1, 1'b0);
    send_item(32'h1, 1'b1, 1'b1);
    end_stream();
    drain();

    apb_write(ADDR_SPARE, 32'h0);
    send_item(32'h3, 1'b1, 1'b0);
    send_item(32'h1, 1'b1, 1'b0);
    send_item(32'h2, 1'b1, 1'b1);
    end_stream();
    drain();

    foreach (settings[k]) begin
      apb_write(ADDR_PERCENT, ($urandom & ~32'h7F) | 32'(settings[k]));
      steady = (k == 3);
      run_phase(105);
    end
    steady = 1'b0;

    drain();
    if (tracker.pending.size() != 0)
      tracker.report($sformatf("%0d results never arrived", tracker.pending.size()));
    if (tracker.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ nearest_rank_percentile_select.f @@
src/nrps_pkg.sv
src/nrps_if.sv
src/nrps_cell.sv
src/nrps_chain.sv
src/nrps_rank.sv
src/nearest_rank_percentile_select.sv
dv/testbench.sv
